/* rtl/scp_pkg.sv */
// types, codes and helpers shared by the serial command parser and transmit queue
package scp_pkg;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_WR_MAIN   = 4'd1,
		ACT_WR_REF    = 4'd2,
		ACT_WR_SET    = 4'd3,
		ACT_SAVE      = 4'd4,
		ACT_VLV_RESET = 4'd5,
		ACT_STEP_OPEN = 4'd6,
		ACT_STEP_CLOSE = 4'd7,
		ACT_FETCH     = 4'd8,
		ACT_FULL      = 4'd9,
		ACT_FLUSH     = 4'd10
	} act_t;

	typedef struct packed {
		act_t       action;
		logic [3:0] source_id;
		logic [7:0] byte_index;
		logic [7:0] write_offset;
		logic [7:0] write_value;
		logic       last_of_job;
		logic       tx_active;
	} rsp_t;

	typedef struct packed {
		logic [3:0] src;
		logic [7:0] last;
	} job_t;

	localparam logic       REQ_TX_TICK = 1'b1;

	localparam logic [3:0] SRC_REALTIME = 4'd0;
	localparam logic [3:0] SRC_RT_EXT   = 4'd1;
	localparam logic [3:0] SRC_TEST     = 4'd2;
	localparam logic [3:0] SRC_VALVE    = 4'd3;
	localparam logic [3:0] SRC_MAIN     = 4'd4;
	localparam logic [3:0] SRC_MAIN_FR  = 4'd5;
	localparam logic [3:0] SRC_REF      = 4'd6;
	localparam logic [3:0] SRC_SET_FULL = 4'd7;
	localparam logic [3:0] SRC_SET_COMP = 4'd8;
	localparam logic [3:0] SRC_SET_EXT  = 4'd9;
	localparam logic [3:0] SRC_VERSION  = 4'd10;

	localparam logic [1:0] WK_NULL = 2'd0;
	localparam logic [1:0] WK_MAIN = 2'd1;
	localparam logic [1:0] WK_REF  = 2'd2;
	localparam logic [1:0] WK_SET  = 2'd3;

	localparam logic [8:0] LEN_REALTIME     = 9'd22;
	localparam logic [8:0] LEN_REALTIME_EXT = 9'd27;
	localparam logic [8:0] LEN_SETTINGS_EXT = 9'h080;
	localparam logic [8:0] LEN_SETTINGS_STD = 9'h07d;
	localparam logic [8:0] LEN_VALVE        = 9'd7;
	localparam logic [8:0] LEN_ONE          = 9'd1;

	localparam logic [7:0] CH_REALTIME  = 8'h41; // A
	localparam logic [7:0] CH_SAVE      = 8'h42; // B
	localparam logic [7:0] CH_TEST      = 8'h43; // C
	localparam logic [7:0] CH_FLUSH     = 8'h46; // F
	localparam logic [7:0] CH_VALVE     = 8'h69; // i
	localparam logic [7:0] CH_MAIN      = 8'h4c; // L
	localparam logic [7:0] CH_MAIN_FR   = 8'h6c; // l
	localparam logic [7:0] CH_REF       = 8'h6d; // m
	localparam logic [7:0] CH_WR_REF    = 8'h4e; // N
	localparam logic [7:0] CH_WR_MAIN   = 8'h6e; // n
	localparam logic [7:0] CH_VERSION   = 8'h51; // Q
	localparam logic [7:0] CH_VLV_RESET = 8'h70; // p
	localparam logic [7:0] CH_STEP_OPEN = 8'h73; // s
	localparam logic [7:0] CH_STEP_CLOSE = 8'h53; // S
	localparam logic [7:0] CH_SET_FULL  = 8'h54; // T
	localparam logic [7:0] CH_SET_COMP  = 8'h56; // V
	localparam logic [7:0] CH_SET_EXT   = 8'h76; // v
	localparam logic [7:0] CH_WR_SET    = 8'h57; // W
	localparam logic [7:0] CH_WR_NULL   = 8'h77; // w

	localparam logic [8:0] RST_MAIN_ENTRIES = 9'd256;
	localparam logic [8:0] RST_REF_ENTRIES  = 9'd256;
	localparam logic [8:0] RST_SET_BYTES    = 9'd128;

	// byte count to last byte index, zero sends one byte, above 256 saturates
	function automatic logic [7:0] count_to_last(input logic [8:0] n);
		logic [7:0] r;
		if (n == 9'd0) begin
			r = 8'd0;
		end else if (n[8]) begin
			r = 8'hff;
		end else begin
			r = n[7:0] - 8'd1;
		end
		return r;
	endfunction

endpackage

/* rtl/serial_command_parser_tx_queue.sv */
// serial command parser with transmit job queue, top level
//
//  channel  dir  handshake            payload
//  cmd      in   cmd_valid/cmd_stall  scp_pkg::cmd_t (req_type, rx_byte)
//  rsp      out  rsp_valid/rsp_stall  scp_pkg::rsp_t (one result per request)
//  apb      in   psel/penable/pwrite  5 registers at byte address 4*i
//
//  one request per cycle sustained while rsp_stall does not hold a valid result; a result
//  passes the input register, then decode and queue update into the result register
//  the job store is one memory with a registered read of the entry behind the tail
//  arst_n clears parser phase, queue pointers, counter and registers to defaults
//  a stalled result holds the request in the input register, which stalls cmd
module serial_command_parser_tx_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  scp_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output scp_pkg::rsp_t  rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int PW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	localparam logic [2:0] REG_EMU  = 3'd0;
	localparam logic [2:0] REG_EXT  = 3'd1;
	localparam logic [2:0] REG_MAIN = 3'd2;
	localparam logic [2:0] REG_REF  = 3'd3;
	localparam logic [2:0] REG_SET  = 3'd4;

	typedef enum logic [1:0] {
		PH_CMD,
		PH_OFFSET,
		PH_VALUE
	} phase_t;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	logic           emu_q;
	logic           ext_q;
	logic [8:0]     main_n_q;
	logic [8:0]     ref_n_q;
	logic [8:0]     set_n_q;

	logic           v_s1;
	scp_pkg::cmd_t  item_s1;
	logic           rsp_valid_q;
	scp_pkg::rsp_t  rsp_q;

	phase_t         phase_q, phase_d;
	logic [1:0]     kind_q, kind_d;
	logic [7:0]     off_q, off_d;
	logic [PW-1:0]  head_q, head_d;
	logic [PW-1:0]  tail_q, tail_d;
	logic [7:0]     cnt_q, cnt_d;
	scp_pkg::job_t  front_q;
	scp_pkg::job_t  rd_q;
	scp_pkg::job_t  mem [QUEUE_DEPTH];

	logic           adv, fire, accept, empty, cfg_wr;
	logic           enq_req, enq_ok, pop;
	logic [3:0]     enq_src;
	logic [8:0]     enq_len;
	scp_pkg::job_t  wjob;
	logic [PW-1:0]  raddr;
	scp_pkg::rsp_t  res_d;
	logic [7:0]     b;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign fire      = v_s1 && adv;
	assign cmd_stall = v_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;
	assign empty     = (head_q == tail_q);
	assign b         = item_s1.rx_byte;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;

	assign wjob.src  = enq_src;
	assign wjob.last = scp_pkg::count_to_last(enq_len);
	assign raddr     = ptr_inc(tail_d);

	always_comb begin
		case (paddr[4:2])
			REG_EMU:  prdata = {31'd0, emu_q};
			REG_EXT:  prdata = {31'd0, ext_q};
			REG_MAIN: prdata = {23'd0, main_n_q};
			REG_REF:  prdata = {23'd0, ref_n_q};
			REG_SET:  prdata = {23'd0, set_n_q};
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		res_d        = '0;
		res_d.action = scp_pkg::ACT_NONE;
		phase_d      = phase_q;
		kind_d       = kind_q;
		off_d        = off_q;
		head_d       = head_q;
		tail_d       = tail_q;
		cnt_d        = cnt_q;
		enq_req      = 1'b0;
		enq_src      = '0;
		enq_len      = '0;
		enq_ok       = 1'b0;
		pop          = 1'b0;
		if (fire) begin
			if (item_s1.req_type == scp_pkg::REQ_TX_TICK) begin
				if (!empty) begin
					res_d.action     = scp_pkg::ACT_FETCH;
					res_d.source_id  = front_q.src;
					res_d.byte_index = cnt_q;
					if (cnt_q < front_q.last) begin
						cnt_d = cnt_q + 8'd1;
					end else begin
						res_d.last_of_job = 1'b1;
						tail_d = ptr_inc(tail_q);
						cnt_d  = '0;
						pop    = 1'b1;
					end
				end
			end else begin
				case (phase_q)
					PH_OFFSET: begin
						off_d   = b;
						phase_d = PH_VALUE;
					end
					PH_VALUE: begin
						phase_d = PH_CMD;
						case (kind_q)
							scp_pkg::WK_MAIN: res_d.action = scp_pkg::ACT_WR_MAIN;
							scp_pkg::WK_REF:  res_d.action = scp_pkg::ACT_WR_REF;
							scp_pkg::WK_SET:  res_d.action = scp_pkg::ACT_WR_SET;
							default:          res_d.action = scp_pkg::ACT_NONE;
						endcase
						if (kind_q != scp_pkg::WK_NULL) begin
							res_d.write_offset = off_q;
							res_d.write_value  = b;
						end
					end
					default: begin
						phase_d = PH_CMD;
						case (b)
							scp_pkg::CH_REALTIME: begin
								enq_req = 1'b1;
								enq_src = emu_q ? scp_pkg::SRC_RT_EXT : scp_pkg::SRC_REALTIME;
								enq_len = emu_q ? scp_pkg::LEN_REALTIME_EXT : scp_pkg::LEN_REALTIME;
							end
							scp_pkg::CH_SAVE: res_d.action = scp_pkg::ACT_SAVE;
							scp_pkg::CH_TEST: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_TEST;
								enq_len = scp_pkg::LEN_ONE;
							end
							scp_pkg::CH_FLUSH: begin
								head_d       = '0;
								tail_d       = '0;
								cnt_d        = '0;
								res_d.action = scp_pkg::ACT_FLUSH;
							end
							scp_pkg::CH_VALVE: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_VALVE;
								enq_len = scp_pkg::LEN_VALVE;
							end
							scp_pkg::CH_MAIN: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_MAIN;
								enq_len = main_n_q;
							end
							scp_pkg::CH_MAIN_FR: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_MAIN_FR;
								enq_len = main_n_q;
							end
							scp_pkg::CH_REF: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_REF;
								enq_len = ref_n_q;
							end
							scp_pkg::CH_WR_REF: begin
								phase_d = PH_OFFSET;
								kind_d  = scp_pkg::WK_REF;
							end
							scp_pkg::CH_WR_MAIN: begin
								phase_d = PH_OFFSET;
								kind_d  = scp_pkg::WK_MAIN;
							end
							scp_pkg::CH_VERSION: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_VERSION;
								enq_len = scp_pkg::LEN_ONE;
							end
							scp_pkg::CH_VLV_RESET:  res_d.action = scp_pkg::ACT_VLV_RESET;
							scp_pkg::CH_STEP_OPEN:  res_d.action = scp_pkg::ACT_STEP_OPEN;
							scp_pkg::CH_STEP_CLOSE: res_d.action = scp_pkg::ACT_STEP_CLOSE;
							scp_pkg::CH_SET_FULL: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_SET_FULL;
								enq_len = set_n_q;
							end
							scp_pkg::CH_SET_COMP: begin
								enq_req = 1'b1;
								enq_src = scp_pkg::SRC_SET_COMP;
								enq_len = emu_q ? scp_pkg::LEN_SETTINGS_EXT
								                : scp_pkg::LEN_SETTINGS_STD;
							end
							scp_pkg::CH_SET_EXT: begin
								enq_req = ext_q;
								enq_src = scp_pkg::SRC_SET_EXT;
								enq_len = scp_pkg::LEN_SETTINGS_EXT;
							end
							scp_pkg::CH_WR_SET: begin
								phase_d = PH_OFFSET;
								kind_d  = scp_pkg::WK_SET;
							end
							scp_pkg::CH_WR_NULL: begin
								if (ext_q) begin
									phase_d = PH_OFFSET;
									kind_d  = scp_pkg::WK_NULL;
								end
							end
							default: ;
						endcase
					end
				endcase
				if (enq_req) begin
					if (ptr_inc(head_q) == tail_q) begin
						res_d.action = scp_pkg::ACT_FULL;
					end else begin
						enq_ok = 1'b1;
						head_d = ptr_inc(head_q);
					end
				end
			end
			res_d.tx_active = (head_d != tail_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emu_q       <= 1'b0;
			ext_q       <= 1'b0;
			main_n_q    <= scp_pkg::RST_MAIN_ENTRIES;
			ref_n_q     <= scp_pkg::RST_REF_ENTRIES;
			set_n_q     <= scp_pkg::RST_SET_BYTES;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
			phase_q     <= PH_CMD;
			kind_q      <= scp_pkg::WK_NULL;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[4:2])
					REG_EMU:  emu_q    <= pwdata[0];
					REG_EXT:  ext_q    <= pwdata[0];
					REG_MAIN: main_n_q <= pwdata[8:0];
					REG_REF:  ref_n_q  <= pwdata[8:0];
					REG_SET:  set_n_q  <= pwdata[8:0];
					default: ;
				endcase
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			phase_q <= phase_d;
			kind_q  <= kind_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
		end
	end

	// payload registers and job store
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
		if (fire) begin
			rsp_q <= res_d;
		end
		off_q <= off_d;
		if (enq_ok) begin
			mem[head_q] <= wjob;
		end
		// entry behind the tail, with write bypass
		if (enq_ok && (head_q == raddr)) begin
			rd_q <= wjob;
		end else begin
			rd_q <= mem[raddr];
		end
		if (enq_ok && empty) begin
			front_q <= wjob;
		end else if (pop) begin
			front_q <= rd_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cnt_q <= front_q.last))
		else $error("byte counter beyond last index of head job");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (cnt_q == 8'd0))
		else $error("byte counter not cleared with empty queue");

	a_enq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		enq_ok |=> !empty)
		else $error("queue empty after accepted job");

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.action == scp_pkg::ACT_FLUSH)) |-> !rsp_q.tx_active)
		else $error("flush result reports active transmit");
`endif

endmodule
